FILE: hw/rtl/wpsr_pkg.sv
// ----------------------------------------------------------------------------
// wpsr_pkg
// Shared constants, types and helpers of the weighted prefix select-remove
// block: memory word layout, write port bundle, controller states.
// ----------------------------------------------------------------------------
package wpsr_pkg;

	localparam int MAX_VALUES = 1024;
	localparam int VAL_W      = $clog2(MAX_VALUES);
	localparam int CNT_W      = VAL_W + 1;
	localparam int SUM_W      = 20;
	localparam int DIFF_W     = SUM_W + 2;
	localparam int K_W        = $clog2(VAL_W);

	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_SELECT  = 1'b1;

	typedef logic [VAL_W-1:0] addr_t;

	typedef struct packed {
		logic             removed;
		logic [SUM_W-1:0] weight;
	} tree_word_t;

	typedef struct packed {
		logic       en;
		addr_t      addr;
		tree_word_t data;
	} tree_wr_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DESCEND,
		ST_UPD_ISSUE,
		ST_UPD_CHECK,
		ST_UPD_WALK,
		ST_CLEAR,
		ST_DONE
	} state_t;

	localparam addr_t FIRST_NP = addr_t'(1) << (VAL_W - 1);

	// Sum of 1..2^k: the full weight a tree entry of span 2^k adds above its base.
	function automatic logic [SUM_W-1:0] tri_step(input logic [K_W-1:0] k);
		int kk;
		kk = int'(k);
		if (kk == 0) begin
			return SUM_W'(1);
		end
		return (SUM_W'(1) << (2 * kk - 1)) | (SUM_W'(1) << (kk - 1));
	endfunction

endpackage

FILE: hw/rtl/weighted_prefix_select_remove.sv
// ----------------------------------------------------------------------------
// weighted_prefix_select_remove
// Keeps the set of values 1..n, each weighing its own size. A restart beat
// refills the set; a select beat returns the largest value whose remaining
// weight below it is at most target_sum, then removes that value.
//
// Removed weight lives in a Fenwick tree held in a single-port-read,
// single-port-write memory with a registered read. A select walks the
// tree top-down, one entry per cycle, then adds the chosen value along its
// update path, one entry per cycle (up to 11 entries). A restart clears the
// memory one entry per cycle. After reset a clearing pass over all 1024
// entries runs before the first input beat is taken; configuration writes
// are taken at any time. A finished result waits in an output register
// while the next input beat is taken.
// ----------------------------------------------------------------------------
module weighted_prefix_select_remove (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wpsr_pkg::CNT_W-1:0]   value_count,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [wpsr_pkg::SUM_W-1:0]   target_sum,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wpsr_pkg::CNT_W-1:0]   chosen_value
);

	wpsr_pkg::state_t       state_q, state_d;
	logic [wpsr_pkg::CNT_W-1:0] value_count_q;
	wpsr_pkg::addr_t        clr_q;
	logic                   out_valid_q;
	logic [wpsr_pkg::CNT_W-1:0] chosen_q;

	logic [wpsr_pkg::K_W-1:0]   k_q;
	wpsr_pkg::addr_t        pos_q;
	logic [wpsr_pkg::SUM_W-1:0] slack_q;
	wpsr_pkg::addr_t        nm1_q;
	logic [wpsr_pkg::CNT_W-1:0] v_q;
	logic [wpsr_pkg::CNT_W-1:0] idx_q;

	wpsr_pkg::tree_wr_t     tree_wr;
	wpsr_pkg::addr_t        rd_addr;
	wpsr_pkg::tree_word_t   rd_data;

	logic                   in_fire;
	logic                   out_free;
	logic                   out_ld;

	logic [wpsr_pkg::CNT_W-1:0] cnt_m1;
	wpsr_pkg::addr_t        nm1_cfg;

	wpsr_pkg::addr_t        np;
	logic [wpsr_pkg::SUM_W-1:0] lhs;
	logic [wpsr_pkg::DIFF_W-1:0] diff;
	logic                   take;
	wpsr_pkg::addr_t        pos_nx;
	logic [wpsr_pkg::SUM_W-1:0] slack_nx;
	logic [wpsr_pkg::K_W-1:0]   k_dn;

	logic [wpsr_pkg::CNT_W-1:0] v_nx;
	logic [wpsr_pkg::CNT_W-1:0] low_bit;
	logic [wpsr_pkg::CNT_W:0]   idx_nx;
	logic                   walk_more;
	logic [wpsr_pkg::SUM_W-1:0] upd_sum;

	wpsr_tree_ram u_tree_ram (
		.clk     (clk),
		.wr      (tree_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign chosen_value = chosen_q;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_ld   = (state_q == wpsr_pkg::ST_DONE) && out_free;

	// clamp count to 1..MAX_VALUES
	assign cnt_m1 = value_count_q - wpsr_pkg::CNT_W'(1);
	always_comb begin
		if (value_count_q == '0) begin
			nm1_cfg = '0;
		end else if (value_count_q > wpsr_pkg::CNT_W'(wpsr_pkg::MAX_VALUES)) begin
			nm1_cfg = '1;
		end else begin
			nm1_cfg = cnt_m1[wpsr_pkg::VAL_W-1:0];
		end
	end

	// descent step: remaining weight in (pos, np] against slack
	assign np   = pos_q | (wpsr_pkg::addr_t'(1) << k_q);
	assign lhs  = (wpsr_pkg::SUM_W'(pos_q) << k_q) + wpsr_pkg::tri_step(k_q);
	assign diff = {2'b00, slack_q} + {2'b00, rd_data.weight} - {2'b00, lhs};
	assign take = !diff[wpsr_pkg::DIFF_W-1] && (np <= nm1_q);
	assign pos_nx   = take ? np : pos_q;
	assign slack_nx = take ? diff[wpsr_pkg::SUM_W-1:0] : slack_q;
	assign k_dn     = k_q - wpsr_pkg::K_W'(1);

	// update walk
	assign v_nx      = wpsr_pkg::CNT_W'(pos_q) + wpsr_pkg::CNT_W'(1);
	assign low_bit   = idx_q & (~idx_q + wpsr_pkg::CNT_W'(1));
	assign idx_nx    = {1'b0, idx_q} + {1'b0, low_bit};
	assign walk_more = idx_nx <= (wpsr_pkg::CNT_W + 1)'(wpsr_pkg::MAX_VALUES);
	assign upd_sum   = rd_data.weight + wpsr_pkg::SUM_W'(v_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wpsr_pkg::ST_INIT: begin
				if (clr_q == '1) begin
					state_d = wpsr_pkg::ST_IDLE;
				end
			end
			wpsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (mode == wpsr_pkg::MODE_SELECT) ? wpsr_pkg::ST_DESCEND
						: wpsr_pkg::ST_CLEAR;
				end
			end
			wpsr_pkg::ST_DESCEND: begin
				if (k_q == '0) begin
					state_d = wpsr_pkg::ST_UPD_ISSUE;
				end
			end
			wpsr_pkg::ST_UPD_ISSUE: begin
				state_d = wpsr_pkg::ST_UPD_CHECK;
			end
			wpsr_pkg::ST_UPD_CHECK: begin
				if (rd_data.removed || !walk_more) begin
					state_d = wpsr_pkg::ST_DONE;
				end else begin
					state_d = wpsr_pkg::ST_UPD_WALK;
				end
			end
			wpsr_pkg::ST_UPD_WALK: begin
				if (!walk_more) begin
					state_d = wpsr_pkg::ST_DONE;
				end
			end
			wpsr_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = wpsr_pkg::ST_DONE;
				end
			end
			wpsr_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = wpsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wpsr_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_addr  = wpsr_pkg::FIRST_NP;
		tree_wr  = '0;
		unique case (state_q)
			wpsr_pkg::ST_INIT, wpsr_pkg::ST_CLEAR: begin
				tree_wr.en   = 1'b1;
				tree_wr.addr = clr_q;
			end
			wpsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			wpsr_pkg::ST_DESCEND: begin
				if (k_q != '0) begin
					rd_addr = pos_nx | (wpsr_pkg::addr_t'(1) << k_dn);
				end
			end
			wpsr_pkg::ST_UPD_ISSUE: begin
				rd_addr = v_nx[wpsr_pkg::VAL_W-1:0];
			end
			wpsr_pkg::ST_UPD_CHECK: begin
				rd_addr = idx_nx[wpsr_pkg::VAL_W-1:0];
				if (!rd_data.removed) begin
					tree_wr.en           = 1'b1;
					tree_wr.addr         = idx_q[wpsr_pkg::VAL_W-1:0];
					tree_wr.data.removed = 1'b1;
					tree_wr.data.weight  = upd_sum;
				end
			end
			wpsr_pkg::ST_UPD_WALK: begin
				rd_addr              = idx_nx[wpsr_pkg::VAL_W-1:0];
				tree_wr.en           = 1'b1;
				tree_wr.addr         = idx_q[wpsr_pkg::VAL_W-1:0];
				tree_wr.data.removed = rd_data.removed;
				tree_wr.data.weight  = upd_sum;
			end
			wpsr_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wpsr_pkg::ST_INIT;
			value_count_q <= wpsr_pkg::CNT_W'(wpsr_pkg::MAX_VALUES);
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				value_count_q <= value_count;
			end
			if (state_q == wpsr_pkg::ST_INIT || state_q == wpsr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + wpsr_pkg::addr_t'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wpsr_pkg::ST_IDLE: begin
				if (in_fire) begin
					pos_q   <= '0;
					k_q     <= wpsr_pkg::K_W'(wpsr_pkg::VAL_W - 1);
					slack_q <= target_sum;
					nm1_q   <= nm1_cfg;
					v_q     <= '0;
				end
			end
			wpsr_pkg::ST_DESCEND: begin
				pos_q   <= pos_nx;
				slack_q <= slack_nx;
				if (k_q != '0) begin
					k_q <= k_dn;
				end
			end
			wpsr_pkg::ST_UPD_ISSUE: begin
				v_q   <= v_nx;
				idx_q <= v_nx;
			end
			wpsr_pkg::ST_UPD_CHECK, wpsr_pkg::ST_UPD_WALK: begin
				idx_q <= idx_nx[wpsr_pkg::CNT_W-1:0];
			end
			default: begin
			end
		endcase
		if (out_ld) begin
			chosen_q <= v_q;
		end
	end

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == wpsr_pkg::ST_DESCEND || state_q == wpsr_pkg::ST_CLEAR))
		else $error("accepted beat did not start a descent or clear");

	a_no_write_in_descent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wpsr_pkg::ST_DESCEND |-> !tree_wr.en)
		else $error("tree written during descent");

	a_descent_pos_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wpsr_pkg::ST_DESCEND
		|-> (pos_q & ((wpsr_pkg::addr_t'(2) << k_q) - wpsr_pkg::addr_t'(1))) == '0)
		else $error("descent position has bits at or below current step");

	a_walk_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wpsr_pkg::ST_UPD_WALK
		|-> idx_q != '0 && idx_q <= wpsr_pkg::CNT_W'(wpsr_pkg::MAX_VALUES))
		else $error("update walk index out of range");

endmodule

FILE: hw/rtl/wpsr_tree_ram.sv
// ----------------------------------------------------------------------------
// wpsr_tree_ram
// Removed-weight tree store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wpsr_tree_ram (
	input  logic                clk,
	input  wpsr_pkg::tree_wr_t  wr,
	input  wpsr_pkg::addr_t     rd_addr,
	output wpsr_pkg::tree_word_t rd_data
);

	wpsr_pkg::tree_word_t mem_q [wpsr_pkg::MAX_VALUES];
	wpsr_pkg::tree_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
